// File: rtl/core/pfrc_pkg.sv
// Shared types and constants for the permutation / factorial-digit rotation codec.
// Used by the codec top level; depends on nothing else.

package pfrc_pkg;

   // Width of one permutation entry or one factorial digit on the ports.
   localparam int VALUE_W = 4;

   // Width of the length register and its value after reset.
   localparam int LEN_W = 5;
   localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd16;

   // One seen bit for every code that a 4-bit entry can carry.
   localparam int SEEN_W = 1 << VALUE_W;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 2;

   // Register indexes, taken from paddr[3:2].
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_READ,
      ST_COUNT,
      ST_STEP,
      ST_LATCH,
      ST_MOD,
      ST_SRCH_A,
      ST_SRCH_B,
      ST_COMMIT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/core/pfrc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the codec for its work and result stores.

module pfrc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/permutation_factorial_rotation_codec.sv
// Top level of the permutation / rotation factorial-digit codec.
// Depends on pfrc_pkg (types, constants) and pfrc_ram (work and result stores).

// Channel   Ports                                         Transfer
// -------   -------------------------------------------   ----------------------------------
// request   start, busy, req_value                        edge with start high and busy low
// result    rsp_strobe, rsp_result_value, rsp_last,       every cycle with rsp_strobe high
//           rsp_invalid
// config    psel, penable, pwrite, paddr, pwdata,         edge with psel, penable, pwrite
//           prdata, pready                                and pready high (pready is tied high)
//
// Loading takes one transfer per cycle: n entries when encoding, n-1 digits when decoding.
// Encoding then steps through READ, COUNT and STEP for each of the n-1 digits, using the
// registered population-count unit, or skips that phase when the load was not a permutation.
// Decoding steps through READ, LATCH, MOD, a binary search of SRCH_A/SRCH_B pairs over the
// population-count unit and COMMIT for each of the n entries; MOD repeats once per extra
// subtraction when a digit is beyond its radix. Results then follow at one per cycle.
// Synchronous reset returns the configuration registers to their defaults and the
// sequencer to loading; RAM contents are not cleared. busy is high from the last load
// transfer until the cycle before the last result appears; the next load may start
// while that result is out. The receiver cannot stall, so results are never held back.

module permutation_factorial_rotation_codec #(
   parameter int MAX_LENGTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pfrc_pkg::VALUE_W-1:0]         req_value,
   // Result channel.
   output logic                                 rsp_strobe,
   output logic [pfrc_pkg::VALUE_W-1:0]         rsp_result_value,
   output logic                                 rsp_last,
   output logic                                 rsp_invalid,
   // Configuration port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pfrc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [pfrc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pfrc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   // Index width, count width (able to hold MAX_LENGTH itself), stored entry width,
   // digit width and the width of a position sum before the wrap correction.
   localparam int IW = $clog2(MAX_LENGTH);
   localparam int CW = $clog2(MAX_LENGTH + 1);
   localparam int VW = pfrc_pkg::VALUE_W;
   localparam int EW = (IW > VW) ? IW : VW;
   localparam int DW = (CW > VW) ? CW : VW;
   localparam int SW = IW + 1;
   // The population count is split into lanes of LaneBits positions each.
   localparam int LaneBits = 8;
   localparam int LANES = (MAX_LENGTH + LaneBits - 1) / LaneBits;
   localparam int LCW = $clog2(LaneBits + 1);

   localparam logic [MAX_LENGTH-1:0] ONES = {MAX_LENGTH{1'b1}};

   // ---------------------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------------------
   logic                         direction_ff, direction_in;
   logic                         rising_ff, rising_in;
   logic [pfrc_pkg::LEN_W-1:0]   length_ff, length_in;
   logic                         cfg_write;
   logic [pfrc_pkg::CSR_IDX_W-1:0] cfg_index;

   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = paddr[pfrc_pkg::CSR_ADDR_W-1:2];
   assign pready    = 1'b1;

   always_comb begin
      direction_in = direction_ff;
      rising_in    = rising_ff;
      length_in    = length_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            pfrc_pkg::CSR_DIRECTION: direction_in = pwdata[0];
            pfrc_pkg::CSR_RISING:    rising_in    = pwdata[0];
            pfrc_pkg::CSR_LENGTH:    length_in    = pwdata[pfrc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         pfrc_pkg::CSR_DIRECTION: prdata = pfrc_pkg::CSR_DATA_W'(direction_ff);
         pfrc_pkg::CSR_RISING:    prdata = pfrc_pkg::CSR_DATA_W'(rising_ff);
         pfrc_pkg::CSR_LENGTH:    prdata = pfrc_pkg::CSR_DATA_W'(length_ff);
         default:                 prdata = '0;
      endcase
   end

   // Effective length n, clamped into 2 .. MAX_LENGTH.
   logic [CW-1:0] n_len;

   always_comb begin
      if (length_ff < 5'd2) begin
         n_len = CW'(2);
      end else if (32'(length_ff) > 32'(MAX_LENGTH)) begin
         n_len = CW'(MAX_LENGTH);
      end else begin
         n_len = CW'(length_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer and run state.
   // ---------------------------------------------------------------------------------------
   pfrc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                loaded_ff, loaded_in;
   logic [pfrc_pkg::SEEN_W-1:0]  seen_ff, seen_in;
   logic                         error_ff, error_in;
   logic [CW-1:0]                k_ff, k_in;
   logic [IW-1:0]                ptr_ff, ptr_in;
   logic [MAX_LENGTH-1:0]        alive_ff, alive_in;
   logic [IW-1:0]                o_ff, o_in;
   logic [IW-1:0]                bitm_ff, bitm_in;
   logic [DW-1:0]                d_ff, d_in;
   logic [CW-1:0]                e_ff, e_in;
   logic [LCW-1:0]               lane_ff [LANES];
   logic [LCW-1:0]               lane_in [LANES];
   logic                         emit_valid_ff, emit_last_ff, emit_invalid_ff, emit_zero_ff;
   logic                         emit_last_in;

   // Memory interfaces.
   logic              wk_we;
   logic [IW-1:0]     wk_rd_addr;
   logic [EW-1:0]     wk_rd_data;
   logic              res_we;
   logic [IW-1:0]     res_wr_addr;
   logic [VW-1:0]     res_wr_data;
   logic [VW-1:0]     res_rd_data;

   // Load-phase decode.
   logic                        accept;
   logic [CW-1:0]               load_total;
   logic                        last_load;
   logic [CW:0]                 radix;
   logic                        enc_bad, dec_bad, error_next;
   logic [pfrc_pkg::SEEN_W-1:0] value_bit;
   logic [MAX_LENGTH-1:0]       alive_init;

   assign accept     = start && (state_ff == pfrc_pkg::ST_LOAD);
   assign load_total = direction_ff ? (n_len - CW'(1)) : n_len;
   assign last_load  = (loaded_ff + CW'(1)) == load_total;
   assign alive_init = ~(ONES << n_len);

   // Rising digits have radix index+2, falling digits have radix n-index.
   assign radix = rising_ff ? ((CW + 1)'(loaded_ff) + (CW + 1)'(2))
                            : ((CW + 1)'(n_len) - (CW + 1)'(loaded_ff));

   always_comb begin
      value_bit = '0;
      value_bit[req_value] = 1'b1;
   end

   assign enc_bad    = (32'(req_value) >= 32'(n_len)) || seen_ff[req_value];
   assign dec_bad    = 32'(req_value) >= 32'(radix);
   assign error_next = error_ff || (direction_ff ? dec_bad : enc_bad);

   // Compute-phase addressing. The rising order reads digits, or places encoded digits,
   // from the far end of the store. Permutation entries are always read in index order.
   logic [CW-1:0] far_index;
   logic [IW-1:0] step_addr;
   logic          k_at_n2, k_at_n1;
   logic [CW-1:0] emit_last_index;
   logic          emit_end;

   assign far_index  = n_len - CW'(2) - k_ff;
   assign step_addr  = rising_ff ? far_index[IW-1:0] : k_ff[IW-1:0];
   assign wk_rd_addr = direction_ff ? step_addr : k_ff[IW-1:0];
   assign k_at_n2    = k_ff == (n_len - CW'(2));
   assign k_at_n1    = k_ff == (n_len - CW'(1));
   assign emit_last_index = direction_ff ? (n_len - CW'(1)) : (n_len - CW'(2));
   assign emit_end   = e_ff == emit_last_index;

   // ---------------------------------------------------------------------------------------
   // Shared counting unit: counts the live positions in the cyclic span that starts at the
   // pointer and ends just before span_hi. The tails of the rotation scheme keep their
   // original cyclic order, so a rotation amounts to moving the pointer and retiring one
   // position. The count is registered per lane and summed in the next cycle.
   // ---------------------------------------------------------------------------------------
   logic [IW-1:0]           cand, off_sel, pos;
   logic [SW-1:0]           dec_sum, dec_fold;
   logic                    dec_wrap, enc_wrap, span_wrap;
   logic [IW-1:0]           dec_abs, span_hi;
   logic [MAX_LENGTH-1:0]   t_lo, t_hi, span, hits;
   logic [LANES*LaneBits-1:0] hits_pad;
   logic [CW-1:0]           f_sum;

   assign cand     = o_ff | bitm_ff;
   assign off_sel  = (state_ff == pfrc_pkg::ST_SRCH_A) ? cand : o_ff;
   assign dec_sum  = SW'(ptr_ff) + SW'(off_sel);
   assign dec_wrap = 32'(dec_sum) >= 32'(n_len);
   assign dec_fold = dec_wrap ? (dec_sum - SW'(n_len)) : dec_sum;
   assign dec_abs  = dec_fold[IW-1:0];

   assign pos      = wk_rd_data[IW-1:0];
   assign enc_wrap = pos < ptr_ff;

   assign span_hi   = direction_ff ? dec_abs : pos;
   assign span_wrap = direction_ff ? dec_wrap : enc_wrap;
   assign t_lo      = ONES << ptr_ff;
   assign t_hi      = ONES << span_hi;
   assign span      = span_wrap ? ~(t_hi & ~t_lo) : (t_lo & ~t_hi);
   assign hits      = alive_ff & span;
   assign hits_pad  = (LANES * LaneBits)'(hits);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_in[l] = '0;
         for (int b = 0; b < LaneBits; b++) begin
            lane_in[l] = lane_in[l] + LCW'(hits_pad[l * LaneBits + b]);
         end
      end
   end

   always_comb begin
      f_sum = '0;
      for (int l = 0; l < LANES; l++) begin
         f_sum = f_sum + CW'(lane_ff[l]);
      end
   end

   // Decode helpers: remaining tail length, digit reduction and the search test.
   logic [DW-1:0] len_dw;
   logic          mod_ge, srch_ok;

   assign len_dw  = DW'(n_len - k_ff);
   assign mod_ge  = d_ff >= len_dw;
   assign srch_ok = (32'(cand) < 32'(n_len)) && (32'(f_sum) <= 32'(d_ff));

   // ---------------------------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfrc_pkg::ST_LOAD: begin
            if (accept && last_load) begin
               // A load that is not a permutation skips the search and reports zeros.
               state_in = (!direction_ff && error_next) ? pfrc_pkg::ST_EMIT
                                                        : pfrc_pkg::ST_READ;
            end
         end
         pfrc_pkg::ST_READ:   state_in = direction_ff ? pfrc_pkg::ST_LATCH : pfrc_pkg::ST_COUNT;
         pfrc_pkg::ST_COUNT:  state_in = pfrc_pkg::ST_STEP;
         pfrc_pkg::ST_STEP:   state_in = k_at_n2 ? pfrc_pkg::ST_EMIT : pfrc_pkg::ST_READ;
         pfrc_pkg::ST_LATCH:  state_in = pfrc_pkg::ST_MOD;
         pfrc_pkg::ST_MOD:    state_in = mod_ge ? pfrc_pkg::ST_MOD : pfrc_pkg::ST_SRCH_A;
         pfrc_pkg::ST_SRCH_A: state_in = pfrc_pkg::ST_SRCH_B;
         pfrc_pkg::ST_SRCH_B: state_in = bitm_ff[0] ? pfrc_pkg::ST_COMMIT : pfrc_pkg::ST_SRCH_A;
         pfrc_pkg::ST_COMMIT: state_in = k_at_n1 ? pfrc_pkg::ST_EMIT : pfrc_pkg::ST_READ;
         pfrc_pkg::ST_EMIT:   state_in = emit_end ? pfrc_pkg::ST_LOAD : pfrc_pkg::ST_EMIT;
         default:             state_in = pfrc_pkg::ST_LOAD;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer outputs.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      busy   = 1'b1;
      wk_we  = 1'b0;
      res_we = 1'b0;
      unique case (state_ff)
         pfrc_pkg::ST_LOAD: begin
            busy  = 1'b0;
            wk_we = start;
         end
         pfrc_pkg::ST_STEP:   res_we = 1'b1;
         pfrc_pkg::ST_COMMIT: res_we = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Datapath next values.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      loaded_in   = loaded_ff;
      seen_in     = seen_ff;
      error_in    = error_ff;
      k_in        = k_ff;
      ptr_in      = ptr_ff;
      alive_in    = alive_ff;
      o_in        = o_ff;
      bitm_in     = bitm_ff;
      d_in        = d_ff;
      e_in        = e_ff;
      res_wr_addr = k_ff[IW-1:0];
      res_wr_data = '0;
      unique case (state_ff)
         pfrc_pkg::ST_LOAD: begin
            if (accept) begin
               loaded_in = loaded_ff + CW'(1);
               error_in  = error_next;
               if (!direction_ff && !enc_bad) begin
                  seen_in = seen_ff | value_bit;
               end
               if (last_load) begin
                  k_in     = '0;
                  ptr_in   = '0;
                  alive_in = alive_init;
                  e_in     = '0;
               end
            end
         end
         pfrc_pkg::ST_STEP: begin
            // Encoded digit: live positions passed on the way to this value's position.
            res_wr_addr   = step_addr;
            res_wr_data   = VW'(f_sum);
            alive_in[pos] = 1'b0;
            ptr_in        = pos;
            k_in          = k_ff + CW'(1);
         end
         pfrc_pkg::ST_LATCH: begin
            // The final entry has no digit; it is the only live position left.
            d_in    = k_at_n1 ? '0 : DW'(wk_rd_data);
            o_in    = '0;
            bitm_in = IW'(1) << (IW - 1);
         end
         pfrc_pkg::ST_MOD: begin
            if (mod_ge) begin
               d_in = d_ff - len_dw;
            end
         end
         pfrc_pkg::ST_SRCH_B: begin
            if (srch_ok) begin
               o_in = cand;
            end
            bitm_in = bitm_ff >> 1;
         end
         pfrc_pkg::ST_COMMIT: begin
            res_wr_addr       = k_ff[IW-1:0];
            res_wr_data       = VW'(dec_abs);
            alive_in[dec_abs] = 1'b0;
            ptr_in            = dec_abs;
            k_in              = k_ff + CW'(1);
         end
         pfrc_pkg::ST_EMIT: begin
            e_in = e_ff + CW'(1);
            if (emit_end) begin
               loaded_in = '0;
               seen_in   = '0;
               error_in  = '0;
            end
         end
         default: ;
      endcase
      // Any register write abandons a partial load.
      if (cfg_write) begin
         loaded_in = '0;
         seen_in   = '0;
         error_in  = '0;
      end
   end

   assign emit_last_in = (state_ff == pfrc_pkg::ST_EMIT) && emit_end;

   // ---------------------------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= 1'b0;
         rising_ff     <= 1'b0;
         length_ff     <= pfrc_pkg::LENGTH_RESET;
         state_ff      <= pfrc_pkg::ST_LOAD;
         loaded_ff     <= '0;
         seen_ff       <= '0;
         error_ff      <= 1'b0;
         emit_valid_ff <= 1'b0;
         emit_last_ff  <= 1'b0;
      end else begin
         direction_ff  <= direction_in;
         rising_ff     <= rising_in;
         length_ff     <= length_in;
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         seen_ff       <= seen_in;
         error_ff      <= error_in;
         emit_valid_ff <= (state_ff == pfrc_pkg::ST_EMIT);
         emit_last_ff  <= emit_last_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff            <= k_in;
      ptr_ff          <= ptr_in;
      alive_ff        <= alive_in;
      o_ff            <= o_in;
      bitm_ff         <= bitm_in;
      d_ff            <= d_in;
      e_ff            <= e_in;
      lane_ff         <= lane_in;
      emit_invalid_ff <= error_ff;
      emit_zero_ff    <= error_ff && !direction_ff;
   end

   // ---------------------------------------------------------------------------------------
   // Stores: loaded entries or digits, and results in index order.
   // ---------------------------------------------------------------------------------------
   pfrc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LENGTH)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (wk_we),
      .wr_addr (loaded_ff[IW-1:0]),
      .wr_data (EW'(req_value)),
      .rd_addr (wk_rd_addr),
      .rd_data (wk_rd_data)
   );

   pfrc_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_LENGTH)
   ) u_result_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_wr_addr),
      .wr_data (res_wr_data),
      .rd_addr (e_ff[IW-1:0]),
      .rd_data (res_rd_data)
   );

   // Results leave in the cycle after their read is issued.
   assign rsp_strobe       = emit_valid_ff;
   assign rsp_result_value = emit_zero_ff ? '0 : res_rd_data;
   assign rsp_last         = emit_last_ff;
   assign rsp_invalid      = emit_invalid_ff;

`ifndef SYNTHESIS
   // A result only ever follows a busy cycle, such as one spent in the emission phase.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");

   // The last result closes the run: no result follows it directly.
   a_last_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_strobe)
      else $error("result transfer right after the last one");

   // An encode step always retires a position that is still live.
   a_enc_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfrc_pkg::ST_STEP) |-> alive_ff[pos])
      else $error("encode step on a retired position");

   // The decode search always lands on a live position.
   a_dec_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfrc_pkg::ST_COMMIT) |-> alive_ff[dec_abs])
      else $error("decode search selected a retired position");

   // The search walks exactly one bit at a time.
   a_search_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfrc_pkg::ST_SRCH_A || state_ff == pfrc_pkg::ST_SRCH_B)
         |-> $onehot(bitm_ff))
      else $error("search bit mask is not one-hot");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the permutation / rotation factorial-digit codec.
// Depends on pfrc_pkg and permutation_factorial_rotation_codec; carries its own predictor.
// Directed runs come first, then random runs under changing register settings.
`timescale 1ns / 1ps

module testbench;

   // Index 3 lies beyond the register list. A write there only aborts a partial load.
   localparam logic [pfrc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 220;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 8;

   typedef logic [15:0][pfrc_pkg::VALUE_W-1:0] perm_vec_type;

   typedef struct packed {
      logic [pfrc_pkg::VALUE_W-1:0] value;
      logic last;
      logic invalid;
   } codec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [pfrc_pkg::VALUE_W-1:0] req_value = '0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [pfrc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [pfrc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic busy;
   logic rsp_strobe;
   logic [pfrc_pkg::VALUE_W-1:0] rsp_result_value;
   logic rsp_last;
   logic rsp_invalid;
   logic [pfrc_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   // Predictor copy of the registers and of the run in progress.
   logic dir_q = 1'b0;
   logic rise_q = 1'b0;
   logic [pfrc_pkg::LEN_W-1:0] len_q = pfrc_pkg::LENGTH_RESET;
   perm_vec_type loaded_q;
   int unsigned load_cnt = 0;
   logic [pfrc_pkg::SEEN_W-1:0] seen_q = '0;
   logic err_q = 1'b0;

   codec_result_type conversion_results_due[$];

   int unsigned idle_pct = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned phase_count = 0;

   permutation_factorial_rotation_codec dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_result_value(rsp_result_value),
      .rsp_last(rsp_last),
      .rsp_invalid(rsp_invalid),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #6 clock = ~clock;

   function automatic int unsigned active_length();
      if (len_q < 2) return 2;
      if (len_q > 16) return 16;
      return len_q;
   endfunction

   function automatic perm_vec_type rotate_tail(input perm_vec_type a, input int unsigned off,
                                                input int unsigned len, input int unsigned s);
      perm_vec_type r;
      r = a;
      for (int unsigned i = 0; i < len; i++) r[off + i] = a[off + (i + s) % len];
      return r;
   endfunction

   // Works out what one accepted transfer causes. Only the transfer that completes a run
   // produces results: n-1 digits when encoding, n entries when decoding.
   function automatic void predict_conversion(input logic [pfrc_pkg::VALUE_W-1:0] v);
      int unsigned n, radix, cnt, s, d;
      perm_vec_type res;
      perm_vec_type inv;
      codec_result_type r;
      n = active_length();
      res = '0;
      if (!dir_q) begin
         if (v >= n || seen_q[v]) err_q = 1'b1;
         else seen_q[v] = 1'b1;
         loaded_q[load_cnt] = v;
         load_cnt++;
         if (load_cnt < n) return;
         cnt = n - 1;
         if (!err_q) begin
            inv = '0;
            for (int unsigned k = 0; k < n; k++) inv[loaded_q[k]] = pfrc_pkg::VALUE_W'(k);
            for (int unsigned k = 0; k + 1 < n; k++) begin
               s = 0;
               while (k + s < n && inv[k + s] != k) s++;
               if (k + s >= n) s = 0;
               if (s != 0) inv = rotate_tail(inv, k, n - k, s);
               if (rise_q) res[n - 2 - k] = pfrc_pkg::VALUE_W'(s);
               else res[k] = pfrc_pkg::VALUE_W'(s);
            end
         end
      end else begin
         radix = rise_q ? load_cnt + 2 : n - load_cnt;
         if (v >= radix) err_q = 1'b1;
         loaded_q[load_cnt] = v;
         load_cnt++;
         if (load_cnt < n - 1) return;
         cnt = n;
         for (int unsigned k = 0; k < n; k++) res[k] = pfrc_pkg::VALUE_W'(k);
         for (int unsigned k = 0; k + 1 < n; k++) begin
            d = rise_q ? loaded_q[n - 2 - k] : loaded_q[k];
            d = d % (n - k);
            if (d != 0) res = rotate_tail(res, k, n - k, d);
         end
      end
      for (int unsigned k = 0; k < cnt; k++) begin
         r.value = res[k];
         r.last = (k + 1 == cnt);
         r.invalid = err_q;
         conversion_results_due.push_back(r);
      end
      load_cnt = 0;
      seen_q = '0;
      err_q = 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input codec_result_type want,
                                input codec_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"MISMATCH (%s) at %0t ns: expected value %0d last %0b invalid %0b,",
                   " got value %0d last %0b invalid %0b"},
                  what, $time, want.value, want.last, want.invalid,
                  got.value, got.last, got.invalid);
   endtask

   // The receiver cannot hold results off, so every strobe cycle is a transfer.
   always @(posedge clock) begin : check_results
      codec_result_type got;
      codec_result_type want;
      if (!reset && rsp_strobe) begin
         got.value = rsp_result_value;
         got.last = rsp_last;
         got.invalid = rsp_invalid;
         if (conversion_results_due.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = conversion_results_due.pop_front();
            results_checked++;
            if (got !== want) note_mismatch("wrong field", want, got);
         end
      end
   end

   // Puts one item on the request channel; returns at its accepting edge or after a gap.
   task automatic send_value(input logic [pfrc_pkg::VALUE_W-1:0] value);
      start <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      predict_conversion(value);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_value <= pfrc_pkg::VALUE_W'($urandom);
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Sends count items; the first item is the leftmost hex digit of vals.
   task automatic load_run(input int unsigned count, input logic [63:0] vals);
      for (int unsigned i = 0; i < count; i++) send_value(vals[4 * (count - 1 - i) +: 4]);
   endtask

   // Holds the sender off until every expected result has arrived and the block is idle,
   // then lets a few more cycles pass.
   task automatic wait_conversions_done();
      int unsigned guard;
      start <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while ((conversion_results_due.size() != 0 || busy !== 1'b0) && guard < DRAIN_LIMIT);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Writes one register through a setup and an access cycle, only once the block is idle.
   // The upper data bits are random since the block keeps only the register's own width.
   task automatic write_register(input logic [pfrc_pkg::CSR_IDX_W-1:0] index,
                                 input logic [4:0] value);
      logic [pfrc_pkg::CSR_DATA_W-1:0] data;
      wait_conversions_done();
      data = $urandom;
      if (index == pfrc_pkg::CSR_LENGTH) data[4:0] = value;
      else data[0] = value[0];
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (index)
         pfrc_pkg::CSR_DIRECTION: dir_q = data[0];
         pfrc_pkg::CSR_RISING:    rise_q = data[0];
         pfrc_pkg::CSR_LENGTH:    len_q = data[4:0];
         default:                 ;
      endcase
      load_cnt = 0;
      seen_q = '0;
      err_q = 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [4:0] pick_length();
      int unsigned r, x;
      r = $urandom_range(99);
      if (r < 60) return 5'($urandom_range(2, 6));
      if (r < 80) return 5'($urandom_range(7, 15));
      if (r < 90) return 5'd16;
      x = $urandom_range(16);
      return (x < 2) ? 5'(x) : 5'(x + 15);
   endfunction

   // One run under the current settings: mostly well-formed, sometimes with one bad item,
   // sometimes pure noise. A broken run stops early and is aborted by the next write.
   task automatic send_random_run(input bit broken);
      int unsigned n, count, mode, j;
      perm_vec_type vals;
      logic [pfrc_pkg::VALUE_W-1:0] tmp;
      n = active_length();
      count = dir_q ? n - 1 : n;
      if (!dir_q) begin
         for (int unsigned i = 0; i < n; i++) vals[i] = pfrc_pkg::VALUE_W'(i);
         for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
         end
      end else begin
         for (int unsigned i = 0; i < count; i++)
            vals[i] = pfrc_pkg::VALUE_W'($urandom_range(rise_q ? i + 1 : n - i - 1));
      end
      mode = $urandom_range(99);
      if (mode >= 90) begin
         for (int unsigned i = 0; i < count; i++) vals[i] = pfrc_pkg::VALUE_W'($urandom);
      end else if (mode >= 75) begin
         vals[$urandom_range(count - 1)] = pfrc_pkg::VALUE_W'($urandom);
      end
      if (broken) begin
         if (count < 2) return;
         count = $urandom_range(1, count - 1);
      end
      for (int unsigned i = 0; i < count; i++) send_value(vals[i]);
   endtask

   task automatic test_encode_orders();
      write_register(pfrc_pkg::CSR_LENGTH, 5'd3);
      load_run(3, 'h201);
      write_register(pfrc_pkg::CSR_RISING, 5'd1);
      load_run(3, 'h120);
   endtask

   // A repeated entry and an entry at or beyond n both give all-zero flagged digits.
   task automatic test_bad_permutations();
      write_register(pfrc_pkg::CSR_RISING, 5'd0);
      load_run(3, 'h110);
      load_run(3, 'h0f1);
   endtask

   // Largest digits in both orders, then a digit beyond its radix.
   task automatic test_decode_orders();
      write_register(pfrc_pkg::CSR_DIRECTION, 5'd1);
      write_register(pfrc_pkg::CSR_LENGTH, 5'd4);
      load_run(3, 'h321);
      write_register(pfrc_pkg::CSR_RISING, 5'd1);
      load_run(3, 'h123);
      load_run(3, 'h030);
   endtask

   // Lengths below two behave as two.
   task automatic test_length_clamp();
      write_register(pfrc_pkg::CSR_LENGTH, 5'd0);
      load_run(1, 'hf);
      load_run(1, 'h1);
      write_register(pfrc_pkg::CSR_DIRECTION, 5'd0);
      write_register(pfrc_pkg::CSR_LENGTH, 5'd1);
      load_run(2, 'h01);
   endtask

   // A write, even to the spare index, drops the partial load that came before it.
   task automatic test_abort_partial_load();
      write_register(pfrc_pkg::CSR_LENGTH, 5'd3);
      load_run(1, 'h2);
      write_register(CSR_SPARE, 5'd0);
      load_run(3, 'h021);
   endtask

   // Random settings per phase. Sender gaps cycle through none, 55 and 32 percent, and
   // every fourth phase waits for all results after each run.
   task automatic test_random_settings();
      int unsigned goal;
      bit pressure;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         idle_pct = (phase_count % 3 == 1) ? 55 : (phase_count % 3 == 2) ? 32 : 0;
         pressure = (phase_count % 4 == 2);
         write_register(pfrc_pkg::CSR_DIRECTION, 5'($urandom_range(1)));
         write_register(pfrc_pkg::CSR_RISING, 5'($urandom_range(1)));
         write_register(pfrc_pkg::CSR_LENGTH, (phase_count == 0) ? 5'd31 : pick_length());
         if ($urandom_range(9) == 0) write_register(CSR_SPARE, 5'($urandom));
         repeat ($urandom_range(2, 6)) begin
            send_random_run(1'b0);
            if (pressure) wait_conversions_done();
         end
         if ($urandom_range(99) < 30) send_random_run(1'b1);
         phase_count++;
      end
      idle_pct = 0;
   endtask

   initial begin : run_tests
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_encode_orders();
      test_bad_permutations();
      test_decode_orders();
      test_length_clamp();
      test_abort_partial_load();
      test_random_settings();
      wait_conversions_done();
      if (conversion_results_due.size() != 0) begin
         $display("%0d expected results never arrived", conversion_results_due.size());
         mismatch_count += conversion_results_due.size();
      end
      $display("Sent %0d transfers over %0d random register settings and both directions;",
               items_sent, phase_count);
      $display("checked %0d results, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : watchdog
      #20_000_000;
      $display("Timeout at %0t ns", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
